// File: design/broadcast_gather_index_unit_macros.svh
// ----------------------------------------------------------------------------
// Broadcast gather index unit assertion macros
// Shared macros for the concurrent assertions of the checker.
// ----------------------------------------------------------------------------
`ifndef BROADCAST_GATHER_INDEX_UNIT_MACROS_SVH
`define BROADCAST_GATHER_INDEX_UNIT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define BGI_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bgi assertion failed");

// Next-cycle implication, disabled while rst is high.
`define BGI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bgi assertion failed");

`endif

// File: design/bgi_pkg.sv
// ----------------------------------------------------------------------------
// Broadcast gather index package
// Widths, register indexes and the pipeline payload type.
// ----------------------------------------------------------------------------
package bgi_pkg;

   localparam int IDX_W            = 64;
   localparam int EXT_W            = 16;
   localparam int RANK_W           = 3;
   localparam int DIMS_LIMIT       = 4;
   localparam int BITS_PER_STAGE   = 4;
   localparam int STAGES_PER_DIM   = IDX_W / BITS_PER_STAGE;
   localparam int STRIDE_W         = 3 * EXT_W;
   localparam int MAX_DIMS_DEFAULT = 4;
   localparam int CSR_IDX_W        = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_EXTENTS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_EXTENTS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_RANK    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_RANK    = 2'd3;

   localparam logic [IDX_W-1:0]  EXTENTS_RESET = 64'h0001_0001_0001_0001;
   localparam logic [RANK_W-1:0] RANK_RESET    = 3'd1;

   typedef struct packed {
      logic [IDX_W-1:0]                 quo;
      logic [EXT_W-1:0]                 rem;
      logic [DIMS_LIMIT-1:0][EXT_W-1:0] coord;
   } bgi_div_type;

endpackage

// File: design/bgi_div_stage.sv
// ----------------------------------------------------------------------------
// Broadcast gather index divider stage
// Four restoring division steps of the index by one target extent.
// ----------------------------------------------------------------------------
module bgi_div_stage import bgi_pkg::*; #(
   parameter int DIM   = 0,
   parameter bit FIRST = 1'b0,
   parameter bit LAST  = 1'b0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  bgi_div_type      in_data,
   input  logic [EXT_W-1:0] divisor,
   output logic             out_valid,
   output bgi_div_type      out_data
);

   logic        valid_ff;
   bgi_div_type data_ff;
   bgi_div_type data_in;

   always_comb begin
      logic [EXT_W:0]   r;
      logic [IDX_W-1:0] q;
      r = FIRST ? '0 : {1'b0, in_data.rem};
      q = in_data.quo;
      for (int b = 0; b < BITS_PER_STAGE; b++) begin
         r = {r[EXT_W-1:0], q[IDX_W-1]};
         q = {q[IDX_W-2:0], 1'b0};
         if (r >= {1'b0, divisor}) begin
            r    = r - {1'b0, divisor};
            q[0] = 1'b1;
         end
      end
      data_in     = in_data;
      data_in.quo = q;
      data_in.rem = r[EXT_W-1:0];
      if (LAST) begin
         data_in.coord[DIM] = r[EXT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// File: design/bgi_recompose.sv
// ----------------------------------------------------------------------------
// Broadcast gather index recomposition
// Checks the shapes and rebuilds the source index from the coordinates.
// ----------------------------------------------------------------------------
module bgi_recompose import bgi_pkg::*; #(
   parameter int MAX_DIMS = MAX_DIMS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  bgi_div_type       in_data,
   input  logic [IDX_W-1:0]  target_extents,
   input  logic [IDX_W-1:0]  source_extents,
   input  logic [RANK_W-1:0] trank,
   input  logic [RANK_W-1:0] srank,
   output logic              out_valid,
   output logic [IDX_W-1:0]  source_index,
   output logic              shape_mismatch
);

   logic [STRIDE_W-1:0] stride_ff [MAX_DIMS];
   logic [IDX_W-1:0]    prod_ff   [MAX_DIMS];
   logic [IDX_W-1:0]    prod_in   [MAX_DIMS];
   logic                bad_in;
   logic                bad_a_ff;
   logic                valid_a_ff;
   logic                valid_b_ff;
   logic [IDX_W-1:0]    index_ff;
   logic [IDX_W-1:0]    index_in;
   logic                mismatch_ff;

   for (genvar d = 0; d < MAX_DIMS; d++) begin : g_dim
      if (d == 0) begin : g_first
         always_ff @(posedge clock) begin
            stride_ff[d] <= STRIDE_W'(1);
         end
      end else begin : g_rest
         always_ff @(posedge clock) begin
            stride_ff[d] <= STRIDE_W'(stride_ff[d-1]
                            * source_extents[EXT_W*(d-1) +: EXT_W]);
         end
      end

      always_comb begin
         logic [EXT_W-1:0] c;
         c = '0;
         if (RANK_W'(d) < trank && RANK_W'(d) < srank
             && source_extents[EXT_W*d +: EXT_W] != EXT_W'(1)) begin
            c = in_data.coord[d];
         end
         prod_in[d] = IDX_W'(c) * IDX_W'(stride_ff[d]);
      end
   end

   always_comb begin
      logic [EXT_W-1:0] te;
      logic [EXT_W-1:0] se;
      bad_in = 1'b0;
      for (int d = 0; d < MAX_DIMS; d++) begin
         te = target_extents[EXT_W*d +: EXT_W];
         se = (RANK_W'(d) < srank) ? source_extents[EXT_W*d +: EXT_W] : EXT_W'(1);
         if (RANK_W'(d) < trank) begin
            if (te == '0 || se == '0 || (se != te && se != EXT_W'(1))) begin
               bad_in = 1'b1;
            end
         end else if (RANK_W'(d) < srank && se != EXT_W'(1)) begin
            bad_in = 1'b1;
         end
      end
   end

   always_comb begin
      index_in = '0;
      for (int d = 0; d < MAX_DIMS; d++) begin
         index_in = index_in + prod_ff[d];
      end
      if (bad_a_ff) begin
         index_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else if (advance) begin
         valid_a_ff <= in_valid;
         valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff     <= prod_in;
         bad_a_ff    <= bad_in;
         index_ff    <= index_in;
         mismatch_ff <= bad_a_ff;
      end
   end

   assign out_valid      = valid_b_ff;
   assign source_index   = index_ff;
   assign shape_mismatch = mismatch_ff;

endmodule

// File: design/broadcast_gather_index_unit.sv
// Throughput: one transaction per cycle; each extent division runs as 16
// pipelined stages of four restoring steps, and the whole pipeline halts
// only when a finished result waits on rsp_ready.
// Reset: synchronous, active high; clears all valid bits and loads the
// shape registers with rank 1 and all extents 1.
// ----------------------------------------------------------------------------
// Broadcast gather index unit
// Maps a target tensor index to the index of the source element feeding it.
// ----------------------------------------------------------------------------
module broadcast_gather_index_unit import bgi_pkg::*; #(
   parameter int MAX_DIMS = MAX_DIMS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [IDX_W-1:0]     req_target_index,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [IDX_W-1:0]     rsp_source_index,
   output logic                 rsp_shape_mismatch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [IDX_W-1:0]     csr_wdata
);

   localparam int NSTAGE = MAX_DIMS * STAGES_PER_DIM;

   logic [IDX_W-1:0]  target_extents_ff;
   logic [IDX_W-1:0]  source_extents_ff;
   logic [RANK_W-1:0] target_rank_ff;
   logic [RANK_W-1:0] source_rank_ff;
   logic [RANK_W-1:0] trank;
   logic [RANK_W-1:0] srank;
   logic              advance;
   logic              stage_valid [NSTAGE+1];
   bgi_div_type       stage_data  [NSTAGE+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         target_extents_ff <= EXTENTS_RESET;
         source_extents_ff <= EXTENTS_RESET;
         target_rank_ff    <= RANK_RESET;
         source_rank_ff    <= RANK_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TARGET_EXTENTS: target_extents_ff <= csr_wdata;
            CSR_SOURCE_EXTENTS: source_extents_ff <= csr_wdata;
            CSR_TARGET_RANK:    target_rank_ff    <= csr_wdata[RANK_W-1:0];
            CSR_SOURCE_RANK:    source_rank_ff    <= csr_wdata[RANK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign trank = (target_rank_ff > RANK_W'(MAX_DIMS)) ? RANK_W'(MAX_DIMS) : target_rank_ff;
   assign srank = (source_rank_ff > RANK_W'(MAX_DIMS)) ? RANK_W'(MAX_DIMS) : source_rank_ff;

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   always_comb begin
      stage_valid[0]      = req_valid;
      stage_data[0].quo   = req_target_index;
      stage_data[0].rem   = '0;
      stage_data[0].coord = '0;
   end

   for (genvar s = 0; s < NSTAGE; s++) begin : g_stage
      localparam int D = s / STAGES_PER_DIM;
      bgi_div_stage #(
         .DIM   (D),
         .FIRST ((s % STAGES_PER_DIM) == 0),
         .LAST  ((s % STAGES_PER_DIM) == STAGES_PER_DIM - 1)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (stage_valid[s]),
         .in_data   (stage_data[s]),
         .divisor   (target_extents_ff[EXT_W*D +: EXT_W]),
         .out_valid (stage_valid[s+1]),
         .out_data  (stage_data[s+1])
      );
   end

   bgi_recompose #(
      .MAX_DIMS (MAX_DIMS)
   ) u_recompose (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .in_valid       (stage_valid[NSTAGE]),
      .in_data        (stage_data[NSTAGE]),
      .target_extents (target_extents_ff),
      .source_extents (source_extents_ff),
      .trank          (trank),
      .srank          (srank),
      .out_valid      (rsp_valid),
      .source_index   (rsp_source_index),
      .shape_mismatch (rsp_shape_mismatch)
   );

endmodule

// File: design/bgi_checker.sv
// ----------------------------------------------------------------------------
// Broadcast gather index checker
// Port-level assertions on the request and response transactions.
// ----------------------------------------------------------------------------
`include "broadcast_gather_index_unit_macros.svh"

module bgi_checker import bgi_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [IDX_W-1:0] rsp_source_index,
   input logic             rsp_shape_mismatch
);

   `BGI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_source_index))
   `BGI_ASSERT_NOW(a_mismatch_zero, clock, reset, rsp_valid && rsp_shape_mismatch, rsp_source_index == '0)
   `BGI_ASSERT_NOW(a_stall_blocks_req, clock, reset, rsp_valid && !rsp_ready, !req_ready)
   `BGI_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind broadcast_gather_index_unit bgi_checker u_bgi_checker (.*);

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Broadcast gather index unit testbench
// Drives target indexes through several broadcast shape settings and checks
// every returned source index and mismatch flag against a behavioral model.
// ----------------------------------------------------------------------------
class gather_scoreboard;
   typedef struct {
      logic [63:0] source_index;
      logic        shape_mismatch;
   } gather_result;

   gather_result pending[$];
   logic [63:0]  target_extents = 64'h0001_0001_0001_0001;
   logic [63:0]  source_extents = 64'h0001_0001_0001_0001;
   logic [2:0]   target_rank = 3'd1;
   logic [2:0]   source_rank = 3'd1;
   int           errors = 0;

   function void write_register(logic [1:0] index, logic [63:0] value);
      case (index)
         bgi_pkg::CSR_TARGET_EXTENTS: target_extents = value;
         bgi_pkg::CSR_SOURCE_EXTENTS: source_extents = value;
         bgi_pkg::CSR_TARGET_RANK: target_rank = value[2:0];
         default: source_rank = value[2:0];
      endcase
   endfunction

   function void note_request(logic [63:0] target_index);
      int unsigned trank, srank;
      logic [63:0] te, se, rest, stride, acc, c;
      logic [63:0] coord[4];
      logic        bad;
      gather_result r;
      trank = (target_rank > 4) ? 4 : target_rank;
      srank = (source_rank > 4) ? 4 : source_rank;
      bad = 0;
      rest = target_index;
      acc = 0;
      stride = 1;
      for (int d = 0; d < 4; d++) coord[d] = 0;
      for (int d = 0; d < trank; d++) begin
         te = target_extents[16*d +: 16];
         se = (d < srank) ? source_extents[16*d +: 16] : 64'd1;
         if (te == 0 || se == 0 || (se != te && se != 1)) bad = 1;
      end
      for (int d = trank; d < srank; d++)
         if (source_extents[16*d +: 16] != 16'd1) bad = 1;
      if (!bad) begin
         for (int d = 0; d < trank; d++) begin
            te = target_extents[16*d +: 16];
            coord[d] = rest % te;
            rest = rest / te;
         end
         for (int d = 0; d < srank; d++) begin
            se = source_extents[16*d +: 16];
            c = (d < trank && se != 1) ? coord[d] : 64'd0;
            acc = acc + c * stride;
            stride = stride * se;
         end
      end
      r.source_index = bad ? 64'd0 : acc;
      r.shape_mismatch = bad;
      pending.push_back(r);
   endfunction

   function void check_response(logic [63:0] source_index, logic shape_mismatch);
      gather_result r;
      if (pending.size() == 0) begin
         $error("unexpected transaction source_index=%h", source_index);
         errors++;
         return;
      end
      r = pending.pop_front();
      if (source_index !== r.source_index) begin
         $error("source_index expected %h actual %h", r.source_index, source_index);
         errors++;
      end
      if (shape_mismatch !== r.shape_mismatch) begin
         $error("shape_mismatch expected %b actual %b", r.shape_mismatch, shape_mismatch);
         errors++;
      end
   endfunction
endclass

module testbench;
   import bgi_pkg::*;

   logic                 clock = 0;
   logic                 reset = 1;
   logic                 req_valid = 0;
   logic                 req_ready;
   logic [IDX_W-1:0]     req_target_index = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 0;
   logic [IDX_W-1:0]     rsp_source_index;
   logic                 rsp_shape_mismatch;
   logic                 csr_we = 0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [IDX_W-1:0]     csr_wdata = '0;
   gather_scoreboard     board = new();
   longint               cycles = 0;
   logic                 feeding = 1;

   broadcast_gather_index_unit dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 80);
   endfunction

   task automatic write_csr(logic [1:0] index, logic [63:0] value);
      @(negedge clock);
      csr_we <= 1;
      csr_index <= index;
      csr_wdata <= value;
      board.write_register(index, value);
      @(negedge clock);
      csr_we <= 0;
   endtask

   task automatic send_index(logic [63:0] value, bit quiet);
      int unsigned gap;
      gap = quiet ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1;
      req_target_index <= value;
      do @(posedge clock); while (!req_ready);
      board.note_request(value);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic logic [63:0] random_extents(int unsigned spread);
      logic [63:0] v;
      for (int d = 0; d < 4; d++)
         v[16*d +: 16] = 16'($urandom_range(1, spread));
      return v;
   endfunction

   function automatic logic [63:0] random_index();
      case ($urandom_range(0, 3))
         0: return {$urandom, $urandom};
         1: return 64'($urandom_range(0, 4095));
         2: return {32'hFFFF_FFFF, $urandom};
         default: return 64'($urandom_range(0, 300));
      endcase
   endfunction

   task automatic setup_shape(logic [63:0] te, logic [63:0] se,
                              logic [2:0] tr, logic [2:0] sr);
      drain();
      write_csr(CSR_TARGET_EXTENTS, te);
      write_csr(CSR_SOURCE_EXTENTS, se);
      write_csr(CSR_TARGET_RANK, {61'd0, tr});
      write_csr(CSR_SOURCE_RANK, {61'd0, sr});
   endtask

   task automatic random_phase(int count);
      logic [63:0] te, se;
      for (int d = 0; d < 4; d++) begin
         te[16*d +: 16] = 16'($urandom_range(1, 7));
         case ($urandom_range(0, 3))
            0: se[16*d +: 16] = 16'd1;
            default: se[16*d +: 16] = te[16*d +: 16];
         endcase
      end
      if ($urandom_range(0, 9) == 0) se = random_extents(65535);
      if ($urandom_range(0, 9) == 0) te = {$urandom, $urandom};
      if ($urandom_range(0, 19) == 0) se[15:0] = 16'd0;
      setup_shape(te, se, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
      for (int i = 0; i < count; i++) send_index(random_index(), 0);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      send_index(64'd0, 1);
      send_index(64'hFFFF_FFFF_FFFF_FFFF, 1);
      setup_shape(64'h0005_0004_0003_0002, 64'h0005_0001_0003_0001, 3'd4, 3'd4);
      send_index(64'd0, 1);
      send_index(64'd119, 1);
      send_index(64'd120, 1);
      send_index(64'd37, 1);
      send_index(64'hFFFF_FFFF_FFFF_FFFF, 1);
      send_index(64'hAAAA_5555_AAAA_5555, 1);
      setup_shape(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 3'd7, 3'd7);
      send_index(64'hFFFF_FFFF_FFFF_FFFF, 1);
      send_index(64'h5555_AAAA_5555_AAAA, 1);
      setup_shape(64'h0001_0001_0007_0006, 64'h0001_0001_0007_0006, 3'd2, 3'd4);
      send_index(64'd41, 1);
      setup_shape(64'h0001_0001_0007_0006, 64'h0001_0003_0007_0006, 3'd2, 3'd3);
      send_index(64'd41, 1);
      setup_shape(64'h0001_0000_0007_0006, 64'h0001_0001_0007_0006, 3'd3, 3'd2);
      send_index(64'd9, 1);
      setup_shape(64'h0001_0001_0007_0006, 64'h0001_0001_0004_0006, 3'd2, 3'd2);
      send_index(64'd9, 1);
      setup_shape(64'h0001_0001_0007_0006, 64'h0001_0001_0007_0006, 3'd0, 3'd2);
      send_index(64'd9, 1);
      setup_shape(64'h0001_0001_0007_0006, 64'h0001_0001_0007_0006, 3'd2, 3'd0);
      send_index(64'd9, 1);
      for (int p = 0; p < 25; p++) random_phase(29);
      drain();
      if (board.errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

   always @(negedge clock) begin
      int unsigned gap;
      if (feeding) begin
         gap = pick_gap();
         if (gap != 0 && $urandom_range(0, 1) == 0) begin
            rsp_ready <= 0;
            feeding <= 0;
            fork begin
               repeat (gap) @(negedge clock);
               rsp_ready <= 1;
               feeding <= 1;
            end join_none
         end else begin
            rsp_ready <= 1;
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid && rsp_ready)
         board.check_response(rsp_source_index, rsp_shape_mismatch);
      if (cycles > 2000000) begin
         $display("status: fail");
         $finish;
      end
   end
endmodule

// File: broadcast_gather_index_unit.f
+incdir+design
design/bgi_pkg.sv
design/bgi_div_stage.sv
design/bgi_recompose.sv
design/broadcast_gather_index_unit.sv
design/bgi_checker.sv
sim/testbench.sv
